### sv/hdlc_frame_encoder_defines.svh
// assertion macros for the hdlc frame encoder
`ifndef HDLC_FRAME_ENCODER_DEFINES_SVH
`define HDLC_FRAME_ENCODER_DEFINES_SVH

// condition holds at every clock edge outside reset
`define HFE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the following cycle
`define HFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/hfe_pkg.sv
// shared types, codes and constants of the hdlc frame encoder
`timescale 1ns / 1ps

package hfe_pkg;

    // input command codes
    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_PAYLOAD = 2'd1;
    localparam logic [1:0] CMD_END     = 2'd2;

    localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
    localparam logic [15:0] CRC_POLY   = 16'h8408;
    localparam logic [15:0] CRC_PRESET = 16'hFFFF;
    localparam logic [7:0]  HDR_CTRL   = 8'h03;
    localparam logic [7:0]  HDR_PROTO  = 8'hCC;
    localparam logic [2:0]  STUFF_RUN  = 3'd5;
    localparam logic [2:0]  LAST_BIT   = 3'd7;
    localparam logic [1:0]  QUEUE_DEPTH = 2'd2;
    localparam logic [1:0]  LAST_HDR   = 2'd3;

    typedef enum logic [1:0] {
        KIND_START,
        KIND_PAYLOAD,
        KIND_END
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLAG,
        ST_DATA
    } st_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } q_entry_t;

    typedef struct packed {
        st_t        state;
        logic [2:0] ones;
    } back_status_t;

    // header byte by position: link id high part, low part, control, protocol
    function automatic logic [7:0] header_byte(input logic [1:0] idx,
                                               input logic [9:0] id);
        logic [7:0] b;
        case (idx)
            2'd0:    b = {id[9:4], 2'b00};
            2'd1:    b = {id[3:0], 4'h0};
            2'd2:    b = HDR_CTRL;
            default: b = HDR_PROTO;
        endcase
        return b;
    endfunction

endpackage

### sv/hfe_front.sv
// front end: accepts commands, classifies them and queues them for the serializer
`timescale 1ns / 1ps

module hfe_front
    import hfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] command,
    input  logic [7:0] data_byte,
    input  logic       pop,
    output logic       q_valid,
    output q_entry_t   q_entry
);

    logic [1:0] count_reg, count_next;
    q_entry_t   slot0_reg, slot0_next;
    q_entry_t   slot1_reg, slot1_next;
    q_entry_t   new_entry;
    logic       known;
    logic       push;

    always_comb
    begin
        new_entry.data = data_byte;
        known          = 1'b1;
        case (command)
            CMD_START:   new_entry.kind = KIND_START;
            CMD_PAYLOAD: new_entry.kind = KIND_PAYLOAD;
            CMD_END:     new_entry.kind = KIND_END;
            default:
            begin
                // unknown code is taken and dropped
                new_entry.kind = KIND_PAYLOAD;
                known          = 1'b0;
            end
        endcase
    end

    assign in_ready = (count_reg != QUEUE_DEPTH);
    assign push     = in_valid && in_ready && known;
    assign q_valid  = (count_reg != 2'd0);
    assign q_entry  = slot0_reg;

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        if (pop)
        begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end
        if (push)
        begin
            if (count_next == 2'd0)
                slot0_next = new_entry;
            else
                slot1_next = new_entry;
            count_next = count_next + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

### sv/hfe_back.sv
// back end: serializes queued commands into stuffed line bits with crc
`timescale 1ns / 1ps

module hfe_back
    import hfe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [9:0]   link_id,
    input  logic         q_valid,
    input  q_entry_t     q_entry,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_ready,
    output logic         line_bit,
    output logic         last,
    output back_status_t status
);

    st_t         state_reg, state_next;
    kind_t       kind_reg, kind_next;
    logic [7:0]  shreg_reg, shreg_next;
    logic [2:0]  bit_cnt_reg, bit_cnt_next;
    logic [1:0]  byte_idx_reg, byte_idx_next;
    logic [15:0] crc_reg, crc_next;
    logic [2:0]  ones_reg, ones_next;
    logic        out_valid_reg;
    logic        out_bit_reg;
    logic        out_last_reg;
    logic        ce;
    logic        stuff;
    logic        emit;
    logic        emit_bit;
    logic        emit_last;
    logic        byte_done;

    // output stage can take a bit when empty or being drained
    assign ce        = !out_valid_reg || out_ready;
    assign stuff     = (ones_reg >= STUFF_RUN);
    assign byte_done = ce && !stuff && (bit_cnt_reg == LAST_BIT);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (q_valid)
                    state_next = (q_entry.kind == KIND_START) ? ST_FLAG : ST_DATA;
            ST_FLAG:
                if (byte_done)
                    state_next = (kind_reg == KIND_END) ? ST_IDLE : ST_DATA;
            ST_DATA:
                if (byte_done)
                begin
                    case (kind_reg)
                        KIND_START:
                            if (byte_idx_reg == LAST_HDR)
                                state_next = ST_IDLE;
                        KIND_END:
                            if (byte_idx_reg != 2'd0)
                                state_next = ST_FLAG;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        kind_next     = kind_reg;
        shreg_next    = shreg_reg;
        bit_cnt_next  = bit_cnt_reg;
        byte_idx_next = byte_idx_reg;
        crc_next      = crc_reg;
        ones_next     = ones_reg;
        pop           = 1'b0;
        emit          = 1'b0;
        emit_bit      = 1'b0;
        emit_last     = 1'b0;
        case (state_reg)
            ST_IDLE:
                if (q_valid)
                begin
                    pop           = 1'b1;
                    kind_next     = q_entry.kind;
                    bit_cnt_next  = 3'd0;
                    byte_idx_next = 2'd0;
                    case (q_entry.kind)
                        KIND_START:
                        begin
                            ones_next = 3'd0;
                            crc_next  = CRC_PRESET;
                        end
                        KIND_END:
                            shreg_next = ~crc_reg[7:0];
                        default:
                            shreg_next = q_entry.data;
                    endcase
                end
            ST_FLAG:
                if (ce)
                begin
                    emit = 1'b1;
                    if (stuff)
                    begin
                        // pending run of ones before the closing flag
                        emit_bit  = 1'b0;
                        ones_next = 3'd0;
                    end
                    else
                    begin
                        emit_bit     = FLAG_BYTE[bit_cnt_reg];
                        bit_cnt_next = bit_cnt_reg + 3'd1;
                        if (bit_cnt_reg == LAST_BIT)
                        begin
                            ones_next = 3'd0;
                            if (kind_reg == KIND_END)
                            begin
                                emit_last = 1'b1;
                                crc_next  = CRC_PRESET;
                            end
                            else
                            begin
                                shreg_next    = header_byte(2'd0, link_id);
                                byte_idx_next = 2'd0;
                            end
                        end
                    end
                end
            ST_DATA:
                if (ce)
                begin
                    emit = 1'b1;
                    if (stuff)
                    begin
                        emit_bit  = 1'b0;
                        ones_next = 3'd0;
                    end
                    else
                    begin
                        emit_bit     = shreg_reg[0];
                        shreg_next   = {1'b0, shreg_reg[7:1]};
                        bit_cnt_next = bit_cnt_reg + 3'd1;
                        ones_next    = shreg_reg[0] ? ones_reg + 3'd1 : 3'd0;
                        if (kind_reg != KIND_END)
                            crc_next = {1'b0, crc_reg[15:1]}
                                       ^ ((crc_reg[0] ^ shreg_reg[0]) ? CRC_POLY : 16'h0000);
                        if (bit_cnt_reg == LAST_BIT)
                        begin
                            case (kind_reg)
                                KIND_START:
                                    if (byte_idx_reg == LAST_HDR)
                                        emit_last = 1'b1;
                                    else
                                    begin
                                        byte_idx_next = byte_idx_reg + 2'd1;
                                        shreg_next    = header_byte(byte_idx_reg + 2'd1,
                                                                    link_id);
                                    end
                                KIND_END:
                                    if (byte_idx_reg == 2'd0)
                                    begin
                                        byte_idx_next = 2'd1;
                                        shreg_next    = ~crc_reg[15:8];
                                    end
                                default:
                                    emit_last = 1'b1;
                            endcase
                        end
                    end
                end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            crc_reg       <= CRC_PRESET;
            ones_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            crc_reg   <= crc_next;
            ones_reg  <= ones_next;
            if (ce)
                out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        shreg_reg    <= shreg_next;
        bit_cnt_reg  <= bit_cnt_next;
        byte_idx_reg <= byte_idx_next;
        if (ce)
        begin
            out_bit_reg  <= emit_bit;
            out_last_reg <= emit_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign line_bit     = out_bit_reg;
    assign last         = out_last_reg;
    assign status.state = state_reg;
    assign status.ones  = ones_reg;

endmodule

### sv/hdlc_frame_encoder.sv
// top level of the hdlc transmit framer with bit stuffing and crc-16 check
`timescale 1ns / 1ps
`include "hdlc_frame_encoder_defines.svh"

// HDLC transmit framer. Each input item is a command: start sends the opening
// flag 0x7E and four header bytes (link id bits 9..4, link id bits 3..0, 0x03,
// 0xCC), payload sends data_byte, end sends the inverted crc-16 (reflected
// 0x8408, preset 0xFFFF) low byte first and the closing flag. Bits leave lsb
// first, one line bit per output item, with a zero stuffed after five ones
// outside flags; last marks the final bit caused by a command, and command
// code 3 is taken and produces nothing. A two-entry command queue sits between
// the accepting front end and the bit serializer, so in_ready drops only while
// the queue is full. The serializer produces at most one line bit per cycle
// through a single output register, and fetches each command from the queue
// in its idle state before sending that command's bits, so it takes no new
// command while it is still sending the last one. link_id is written
// through the cfg channel, which is always ready, and must only change while
// no frame bits are pending.
module hdlc_frame_encoder
    import hfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [9:0] cfg_data,
    // command items
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] command,
    input  logic [7:0] data_byte,
    // line bit items
    output logic       out_valid,
    input  logic       out_ready,
    output logic       line_bit,
    output logic       last
);

    logic [9:0]   link_id_reg;
    logic         q_valid;
    q_entry_t     q_entry;
    logic         pop;
    back_status_t status;

    // link id register, written any time the channel is valid
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            link_id_reg <= 10'd0;
        else if (cfg_valid && cfg_ready)
            link_id_reg <= cfg_data;
    end

    // front end: decode and queue commands
    hfe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .data_byte (data_byte),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_entry   (q_entry)
    );

    // back end: flag, header, payload and crc serializer
    hfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .link_id   (link_id_reg),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .line_bit  (line_bit),
        .last      (last),
        .status    (status)
    );

    // stuffing keeps the run of ones at five or fewer
    `HFE_ASSERT_ALWAYS(a_ones_bounded, status.ones <= STUFF_RUN, "ones run exceeds five")

    // serializer only fetches a command that the queue holds
    `HFE_ASSERT_ALWAYS(a_pop_valid, !pop || q_valid, "pop from empty command queue")

    // an idle serializer with an empty queue stays idle
    `HFE_ASSERT_NEXT(a_idle_holds, (status.state == ST_IDLE) && !q_valid,
        status.state == ST_IDLE, "serializer left idle without a command")

endmodule
